// ===== design/sfsa_pkg.sv =====
package sfsa_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 9;
  localparam int GRANT_W = 8;
  localparam int FREE_W  = 9;
  localparam int CNT_W   = 32;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // write port source
  typedef enum logic [1:0] {
    WR_FILL,         // entry at fill pointer <- fill pointer + reserved count
    WR_IDX_AT_DEPTH, // entry at depth <- latched index
    WR_TOP_TO_HOLE   // entry at match position <- old top entry
  } wr_sel_t;

  typedef enum logic [1:0] {
    GR_ZERO,
    GR_IDX,
    GR_RD
  } grant_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       fill_start;
    logic       fill_step;
    logic       fill_finish;
    logic       scan_start;
    logic       scan_step;
    logic       rd_top;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       depth_inc;
    logic       depth_dec;
    logic       cnt_inc;
    logic       set_res;
    logic       res_ok;
    grant_sel_t grant_sel;
    logic       load_out;
  } sfsa_cmd_t;

  typedef struct packed {
    logic op_alloc;
    logic op_free;
    logic op_clear;
    logic idx_reserved;
    logic idx_any;
    logic stack_empty;
    logic stack_full;
    logic scan_hit;
    logic scan_miss;
    logic fill_done;
  } sfsa_stat_t;

endpackage

// ===== design/sfsa_in_if.sv =====
interface sfsa_in_if;
  import sfsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output operation, output slot_index, input ready);
  modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

// ===== design/sfsa_out_if.sv =====
interface sfsa_out_if;
  import sfsa_pkg::*;

  logic               valid;
  logic               ready;
  logic               success;
  logic [GRANT_W-1:0] granted_slot;
  logic [FREE_W-1:0]  free_slots;
  logic [CNT_W-1:0]   change_count;

  modport source (output valid, output success, output granted_slot, output free_slots,
                  output change_count, input ready);
  modport sink   (input valid, input success, input granted_slot, input free_slots,
                  input change_count, output ready);
endinterface

// ===== design/sfsa_dpath.sv =====
module sfsa_dpath #(
  parameter int SLOTS    = 256,
  parameter int RESERVED = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sfsa_pkg::sfsa_cmd_t         cmd,
  input  logic [sfsa_pkg::OP_W-1:0]   in_operation,
  input  logic [sfsa_pkg::IDX_W-1:0]  in_slot_index,
  output sfsa_pkg::sfsa_stat_t        stat,
  output logic                        out_success,
  output logic [sfsa_pkg::GRANT_W-1:0] out_granted_slot,
  output logic [sfsa_pkg::FREE_W-1:0] out_free_slots,
  output logic [sfsa_pkg::CNT_W-1:0]  out_change_count
);
  import sfsa_pkg::*;

  localparam int ENT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADR_W  = ENT_W;
  localparam int DEP_W  = $clog2(SLOTS + 1);
  localparam int FILL_N = (SLOTS > RESERVED) ? SLOTS - RESERVED : 0;

  logic [ENT_W-1:0]   stack_mem_r [SLOTS];
  logic [ENT_W-1:0]   rd_data_r;
  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [DEP_W-1:0]   depth_r;
  logic [CNT_W-1:0]   count_r;
  logic [DEP_W-1:0]   fill_ptr_r;
  logic [DEP_W-1:0]   scan_ptr_r;
  logic [DEP_W-1:0]   cmp_pos_r;
  logic               cmp_vld_r;
  logic               res_ok_r;
  logic [GRANT_W-1:0] res_grant_r;
  logic               out_success_r;
  logic [GRANT_W-1:0] out_grant_r;
  logic [FREE_W-1:0]  out_free_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               scan_more;
  logic               rd_en;
  logic [ADR_W-1:0]   rd_addr;
  logic [ADR_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [GRANT_W-1:0] grant_nxt;

  assign scan_more = scan_ptr_r < depth_r;
  assign rd_en     = cmd.rd_top | (cmd.scan_step & scan_more);
  assign rd_addr   = cmd.rd_top ? ADR_W'(depth_r - DEP_W'(1)) : scan_ptr_r[ADR_W-1:0];

  always_comb begin
    unique case (cmd.wr_sel)
      WR_FILL: begin
        wr_addr = fill_ptr_r[ADR_W-1:0];
        wr_data = ENT_W'(32'(fill_ptr_r) + 32'(RESERVED));
      end
      WR_IDX_AT_DEPTH: begin
        wr_addr = depth_r[ADR_W-1:0];
        wr_data = ENT_W'(idx_r);
      end
      WR_TOP_TO_HOLE: begin
        wr_addr = cmp_pos_r[ADR_W-1:0];
        wr_data = rd_data_r;
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.grant_sel)
      GR_ZERO: grant_nxt = '0;
      GR_IDX:  grant_nxt = idx_r[GRANT_W-1:0];
      GR_RD:   grant_nxt = GRANT_W'(rd_data_r);
      default: grant_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem_r[rd_addr];
    end
    if (cmd.wr_en || cmd.fill_step) begin
      stack_mem_r[cmd.fill_step ? fill_ptr_r[ADR_W-1:0] : wr_addr] <=
        cmd.fill_step ? ENT_W'(32'(fill_ptr_r) + 32'(RESERVED)) : wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      count_r    <= '0;
      fill_ptr_r <= '0;
      scan_ptr_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      if (cmd.fill_start) begin
        fill_ptr_r <= '0;
      end else if (cmd.fill_step) begin
        fill_ptr_r <= fill_ptr_r + DEP_W'(1);
      end
      if (cmd.fill_finish) begin
        depth_r <= DEP_W'(FILL_N);
      end else if (cmd.depth_inc) begin
        depth_r <= depth_r + DEP_W'(1);
      end else if (cmd.depth_dec) begin
        depth_r <= depth_r - DEP_W'(1);
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        scan_ptr_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        // issue one read a cycle; the compare lands in the cycle after
        cmp_vld_r <= scan_more;
        if (scan_more) begin
          scan_ptr_r <= scan_ptr_r + DEP_W'(1);
        end
      end else if (cmd.rd_top) begin
        // drop the stale compare once the top entry is fetched
        cmp_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      idx_r <= in_slot_index;
    end
    if (cmd.scan_step && scan_more) begin
      cmp_pos_r <= scan_ptr_r;
    end
    if (cmd.set_res) begin
      res_ok_r    <= cmd.res_ok;
      res_grant_r <= grant_nxt;
    end
    if (cmd.load_out) begin
      out_success_r <= res_ok_r;
      out_grant_r   <= res_grant_r;
      out_free_r    <= FREE_W'(depth_r);
      out_count_r   <= count_r;
    end
  end

  always_comb begin
    stat.op_alloc     = (op_r == OP_ALLOC);
    stat.op_free      = (op_r == OP_FREE);
    stat.op_clear     = (op_r == OP_CLEAR);
    stat.idx_reserved = 32'(idx_r) < 32'(RESERVED);
    stat.idx_any      = 32'(idx_r) >= 32'(SLOTS);
    stat.stack_empty  = (depth_r == '0);
    stat.stack_full   = 32'(depth_r) >= 32'(SLOTS);
    stat.scan_hit     = cmp_vld_r && (32'(rd_data_r) == 32'(idx_r));
    stat.scan_miss    = !cmp_vld_r && !scan_more;
    stat.fill_done    = (fill_ptr_r == DEP_W'(FILL_N));
  end

  assign out_success      = out_success_r;
  assign out_granted_slot = out_grant_r;
  assign out_free_slots   = out_free_r;
  assign out_change_count = out_count_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(SLOTS))
    else $error("stack depth beyond slot count");

  a_hit_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_hit |-> cmp_pos_r < depth_r)
    else $error("match position outside the live stack");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1)))
    else $error("change counter moved by more than one");

  a_refill_depth: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.fill_finish) |-> depth_r == DEP_W'(FILL_N))
    else $error("refill left a wrong depth");

endmodule

// ===== design/sfsa_ctrl.sv =====
module sfsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sfsa_pkg::sfsa_stat_t stat,
  output sfsa_pkg::sfsa_cmd_t  cmd
);
  import sfsa_pkg::*;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SCAN,
    S_SWAP_LO,
    S_SWAP_HI,
    S_FILL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_BOOT: begin
        if (stat.fill_done) begin
          cmd.fill_finish = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt   = S_DONE;
        cmd.set_res = 1'b1;
        priority if (stat.op_alloc) begin
          priority if (stat.idx_reserved) begin
            cmd.res_ok    = 1'b1;
            cmd.grant_sel = GR_IDX;
          end else if (stat.idx_any) begin
            if (!stat.stack_empty) begin
              cmd.set_res = 1'b0;
              cmd.rd_top  = 1'b1;
              state_nxt   = S_POP;
            end
          end else begin
            cmd.set_res    = 1'b0;
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (stat.op_free) begin
          priority if (stat.idx_any || stat.stack_full) begin
            cmd.res_ok = 1'b0;
          end else if (stat.idx_reserved) begin
            cmd.res_ok = 1'b1;
          end else begin
            cmd.res_ok    = 1'b1;
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_IDX_AT_DEPTH;
            cmd.depth_inc = 1'b1;
            cmd.cnt_inc   = 1'b1;
          end
        end else if (stat.op_clear) begin
          cmd.set_res    = 1'b0;
          cmd.fill_start = 1'b1;
          state_nxt      = S_FILL;
        end else begin
          cmd.res_ok = 1'b0;
        end
      end
      S_POP: begin
        cmd.set_res   = 1'b1;
        cmd.res_ok    = 1'b1;
        cmd.grant_sel = GR_RD;
        cmd.depth_dec = 1'b1;
        cmd.cnt_inc   = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        priority if (stat.scan_hit) begin
          // fetch the top entry to fill the hole
          cmd.rd_top    = 1'b1;
          cmd.depth_dec = 1'b1;
          cmd.cnt_inc   = 1'b1;
          state_nxt     = S_SWAP_LO;
        end else if (stat.scan_miss) begin
          cmd.set_res   = 1'b1;
          cmd.res_ok    = 1'b1;
          cmd.grant_sel = GR_IDX;
          state_nxt     = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SWAP_LO: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_TOP_TO_HOLE;
        state_nxt  = S_SWAP_HI;
      end
      S_SWAP_HI: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_IDX_AT_DEPTH;
        cmd.set_res   = 1'b1;
        cmd.res_ok    = 1'b1;
        cmd.grant_sel = GR_IDX;
        state_nxt     = S_DONE;
      end
      S_FILL: begin
        if (stat.fill_done) begin
          cmd.fill_finish = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_ok      = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= cmd.load_out | (out_valid_r & ~out_ready);
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("input ready outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_boot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BOOT || state_r == S_FILL) |-> !in_ready_r && !cmd.load_in)
    else $error("item taken during refill");

endmodule

// ===== design/slot_free_stack_allocator_core.sv =====
// Slot allocator with a stack of free slot numbers.
// in_ch carries operation (allocate, free, clear) and slot_index; out_ch
// returns success, granted_slot, free_slots and change_count, one result per
// item. Both are valid/ready channels; a transfer happens when both are high.
// Slots below RESERVED are never stacked; allocate of SLOTS or more pops the
// top entry, allocate of a specific slot searches the stack for it.
// A reserved allocate, a free or a failed request goes from S_DISPATCH
// straight to S_DONE; a pop passes through S_POP; a specific allocate
// scans in S_SCAN (one stack entry compared per cycle through the single
// read port), then on a hit swaps in S_SWAP_LO and S_SWAP_HI; a clear
// refills in S_FILL (one entry written per cycle). in_ch.ready rises on
// the same edge as out_ch.valid, so the next item may enter while
// that result waits. After reset the stack is refilled one entry per
// cycle, with in_ch.ready low.
// When the receiver stalls, the result holds in the output register and the
// block stops in its final state after finishing at most one more item.
module slot_free_stack_allocator_core #(
  parameter int SLOTS    = 256,
  parameter int RESERVED = 8
) (
  input logic        clk,
  input logic        rst_n,
  sfsa_in_if.sink    in_ch,
  sfsa_out_if.source out_ch
);
  import sfsa_pkg::*;

  sfsa_cmd_t  cmd;
  sfsa_stat_t stat;

  sfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfsa_dpath #(
    .SLOTS    (SLOTS),
    .RESERVED (RESERVED)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_ch.operation),
    .in_slot_index    (in_ch.slot_index),
    .stat             (stat),
    .out_success      (out_ch.success),
    .out_granted_slot (out_ch.granted_slot),
    .out_free_slots   (out_ch.free_slots),
    .out_change_count (out_ch.change_count)
  );

endmodule
